// ----- sv/mtrg_pkg.sv -----
package mtrg_pkg;

    localparam int STATE_DEPTH  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = 10;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(STATE_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_SHIFT = IDX_W'(SHIFT_OFFSET);
    localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(STATE_DEPTH - SHIFT_OFFSET);

    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TOP_BIT      = 32'h80000000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

    // access bundle from the sequencer to the state memory
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re_a;
        logic [IDX_W-1:0]  raddr_a;
        logic              re_b;
        logic [IDX_W-1:0]  raddr_b;
    } ram_req_t;

endpackage

// ----- sv/mtrg_state_ram.sv -----
module mtrg_state_ram
(
    input  logic                                clk,
    input  mtrg_pkg::ram_req_t                  req,
    output logic [mtrg_pkg::WORD_W-1:0]         dout_a,
    output logic [mtrg_pkg::WORD_W-1:0]         dout_b
);

    logic [mtrg_pkg::WORD_W-1:0] mem [mtrg_pkg::STATE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read data holds while the port is not enabled
    always_ff @(posedge clk)
    begin
        if (req.re_a)
        begin
            dout_a <= mem[req.raddr_a];
        end
        if (req.re_b)
        begin
            dout_b <= mem[req.raddr_b];
        end
    end

endmodule

// ----- sv/mtrg_twist_temper.sv -----
module mtrg_twist_temper
(
    input  logic [mtrg_pkg::WORD_W-1:0] word_cur,
    input  logic [mtrg_pkg::WORD_W-1:0] word_next,
    input  logic [mtrg_pkg::WORD_W-1:0] word_far,
    output logic [mtrg_pkg::WORD_W-1:0] word_new,
    output logic [mtrg_pkg::WORD_W-1:0] tempered
);

    logic [mtrg_pkg::WORD_W-1:0] y;
    logic [mtrg_pkg::WORD_W-1:0] t1;
    logic [mtrg_pkg::WORD_W-1:0] t2;
    logic [mtrg_pkg::WORD_W-1:0] t3;

    always_comb
    begin
        y = (word_cur & mtrg_pkg::TOP_BIT) | (word_next & mtrg_pkg::LOW_BITS);
        word_new = word_far ^ (y >> 1) ^ (y[0] ? mtrg_pkg::TWIST_XOR : '0);
    end

    always_comb
    begin
        t1 = word_new ^ (word_new >> 11);
        t2 = t1 ^ ((t1 << 7) & mtrg_pkg::TEMPER_B);
        t3 = t2 ^ ((t2 << 15) & mtrg_pkg::TEMPER_C);
        tempered = t3 ^ (t3 >> 18);
    end

endmodule

// ----- sv/mt19937_random_generator_top.sv -----
// 32-bit mersenne twister (mt19937). each request beat draws one tempered word;
// with reseed set the 624-word state is first refilled from seed, and that beat
// returns the first word of the new sequence. the state lives in one 624x32
// memory with two registered read ports; the twist is done lazily, one word per
// draw, in place. a draw loads the response register after states rd2 and calc
// (current and far word read at the accepting edge, next word read, then
// twist + temper + write-back), and the request side opens again at the edge
// that loads it, so no new request is taken while a draw is in flight. a
// reseeding draw first runs the fill pass (one multiply-add per word) and the
// read state rd1 before the draw. after reset the same fill pass runs with seed
// 5489; req_stall stays high throughout it. a finished word waits in the response
// register while the next request is accepted and read; the next draw then holds
// in its last step until that word is taken.
module mt19937_random_generator_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         reseed,
    input  logic [mtrg_pkg::WORD_W-1:0]  seed,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [mtrg_pkg::WORD_W-1:0]  random_word
);

    typedef enum logic [4:0] {
        S_FILL = 5'b00001,  // seeding pass through the memory
        S_IDLE = 5'b00010,  // waiting for a request
        S_RD1  = 5'b00100,  // read current and far word (after a fill)
        S_RD2  = 5'b01000,  // capture them, read next word
        S_CALC = 5'b10000   // twist, temper, write back
    } state_t;

    state_t state_reg, state_next;

    logic [mtrg_pkg::IDX_W-1:0]  word_idx_reg, word_idx_next;   // lazy twist position
    logic [mtrg_pkg::IDX_W-1:0]  fill_idx_reg, fill_idx_next;
    logic                        draw_pend_reg, draw_pend_next; // draw after fill
    logic [mtrg_pkg::WORD_W-1:0] seed_reg, seed_next;
    logic [mtrg_pkg::WORD_W-1:0] prev_reg, prev_next;           // last filled word
    logic [mtrg_pkg::WORD_W-1:0] cur_reg, cur_next;
    logic [mtrg_pkg::WORD_W-1:0] far_reg, far_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [mtrg_pkg::WORD_W-1:0] rsp_word_reg, rsp_word_next;

    mtrg_pkg::ram_req_t          ram_req;
    logic [mtrg_pkg::WORD_W-1:0] ram_dout_a;
    logic [mtrg_pkg::WORD_W-1:0] ram_dout_b;

    logic [mtrg_pkg::IDX_W-1:0]  idx_succ;
    logic [mtrg_pkg::IDX_W-1:0]  idx_far;
    logic [mtrg_pkg::WORD_W-1:0] fill_mix;
    logic [mtrg_pkg::WORD_W-1:0] fill_word;
    logic [mtrg_pkg::WORD_W-1:0] twist_word;
    logic [mtrg_pkg::WORD_W-1:0] temper_word;
    logic                        req_take;
    logic                        rsp_free;

    mtrg_state_ram u_ram
    (
        .clk    (clk),
        .req    (ram_req),
        .dout_a (ram_dout_a),
        .dout_b (ram_dout_b)
    );

    // word k is twisted from old words k, k+1 and k+397 (or the already new ones
    // once those indexes wrap), exactly the in-place order of a full twist
    mtrg_twist_temper u_twist
    (
        .word_cur  (cur_reg),
        .word_next (ram_dout_a),
        .word_far  (far_reg),
        .word_new  (twist_word),
        .tempered  (temper_word)
    );

    assign req_stall   = (state_reg != S_IDLE);
    assign req_take    = req_valid && !req_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign random_word = rsp_word_reg;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    // neighbor indexes of the current word
    assign idx_succ = (word_idx_reg == mtrg_pkg::IDX_LAST) ? '0
                    : word_idx_reg + mtrg_pkg::IDX_W'(1);
    assign idx_far  = (word_idx_reg < mtrg_pkg::IDX_WRAP) ? word_idx_reg + mtrg_pkg::IDX_SHIFT
                    : word_idx_reg - mtrg_pkg::IDX_WRAP;

    // knuth recurrence, one word per cycle
    assign fill_mix  = prev_reg ^ (prev_reg >> 30);
    assign fill_word = (fill_idx_reg == '0) ? seed_reg
                     : (mtrg_pkg::SEED_MULT * fill_mix)
                       + {{(mtrg_pkg::WORD_W - mtrg_pkg::IDX_W){1'b0}}, fill_idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        word_idx_next  = word_idx_reg;
        fill_idx_next  = fill_idx_reg;
        draw_pend_next = draw_pend_reg;
        seed_next      = seed_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        far_next       = far_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        ram_req         = '0;
        ram_req.waddr   = fill_idx_reg;
        ram_req.wdata   = fill_word;
        ram_req.raddr_a = word_idx_reg;
        ram_req.raddr_b = idx_far;

        unique case (state_reg)
            S_FILL:
            begin
                ram_req.we    = 1'b1;
                prev_next     = fill_word;
                fill_idx_next = fill_idx_reg + mtrg_pkg::IDX_W'(1);
                if (fill_idx_reg == mtrg_pkg::IDX_LAST)
                begin
                    fill_idx_next  = '0;
                    word_idx_next  = '0;
                    draw_pend_next = 1'b0;
                    state_next     = draw_pend_reg ? S_RD1 : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    seed_next = seed;
                    if (reseed)
                    begin
                        fill_idx_next  = '0;
                        draw_pend_next = 1'b1;
                        state_next     = S_FILL;
                    end
                    else
                    begin
                        ram_req.re_a = 1'b1;
                        ram_req.re_b = 1'b1;
                        state_next   = S_RD2;
                    end
                end
            end
            S_RD1:
            begin
                ram_req.re_a = 1'b1;
                ram_req.re_b = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cur_next        = ram_dout_a;
                far_next        = ram_dout_b;
                ram_req.re_a    = 1'b1;
                ram_req.raddr_a = idx_succ;
                state_next      = S_CALC;
            end
            S_CALC:
            begin
                // hold here while the previous word is still waiting
                if (rsp_free)
                begin
                    ram_req.we     = 1'b1;
                    ram_req.waddr  = word_idx_reg;
                    ram_req.wdata  = twist_word;
                    rsp_word_next  = temper_word;
                    rsp_valid_next = 1'b1;
                    word_idx_next  = idx_succ;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            word_idx_reg  <= '0;
            fill_idx_reg  <= '0;
            draw_pend_reg <= 1'b0;
            seed_reg      <= mtrg_pkg::DEFAULT_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_idx_reg  <= word_idx_next;
            fill_idx_reg  <= fill_idx_next;
            draw_pend_reg <= draw_pend_next;
            seed_reg      <= seed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        far_reg      <= far_next;
        rsp_word_reg <= rsp_word_next;
    end

endmodule

// ----- sv/mtrg_checker.sv -----
module mtrg_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input logic                         reseed,
    input logic [mtrg_pkg::WORD_W-1:0]  seed,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input logic [mtrg_pkg::WORD_W-1:0]  random_word
);

    // response beat holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("rsp_valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(random_word))
        else $error("random_word changed while stalled");

    // a draw keeps the request side closed while it runs
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall ##1 req_stall)
        else $error("request taken during a draw");

    // reset leaves the request side closed for the seeding pass
    assert property (@(posedge clk)
        !rst_n |=> req_stall && !rsp_valid)
        else $error("block open during reset");

    // a plain draw raises no response before its twist step
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !reseed && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
        else $error("response too early");

endmodule

bind mt19937_random_generator_top mtrg_checker u_mtrg_checker (.*);
